FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LPG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Permutation generator package
// Shared widths, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int unsigned PERM_W       = 64;
  localparam int unsigned ELEM_W       = 4;
  localparam int unsigned SIZE_W       = 5;
  localparam int unsigned MIN_ELEMENTS = 2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } lpg_state_e;

  typedef struct packed {
    logic load_identity;
    logic scan_start;
    logic scan_en;
    logic fill_en;
    logic out_load;
    logic out_finished;
  } lpg_cmd_t;

  typedef struct packed {
    logic ascent;
    logic scan_last;
    logic fill_last;
  } lpg_sts_t;

endpackage

FILE: src/lpg_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one request word: the restart flag.
// ----------------------------------------------------------------------------
interface lpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

FILE: src/lpg_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one result word: the packed permutation and the finished flag.
// ----------------------------------------------------------------------------
interface lpg_rsp_if
  import lpg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PERM_W-1:0] perm_packed;
  logic              finished;

  modport source (output valid, output perm_packed, output finished, input ready);
  modport sink   (input valid, input perm_packed, input finished, output ready);
endinterface

FILE: src/lpg_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Carries one write word for the size register.
// ----------------------------------------------------------------------------
interface lpg_cfg_if
  import lpg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_in_use;

  modport source (output valid, output size_in_use, input ready);
  modport sink   (input valid, input size_in_use, output ready);
endinterface

FILE: src/lpg_datapath.sv
// ----------------------------------------------------------------------------
// Permutation datapath
// Holds the permutation, the size register, the scan and refill registers and
// the output word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpg_datapath
  import lpg_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpg_cmd_t          cmd_i,
  output lpg_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_size_i,
  output logic [PERM_W-1:0] perm_packed_o,
  output logic              finished_o
);

  localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic [ELEM_W-1:0]       perm_q [MAX_ELEMENTS];
  logic [ELEM_W-1:0]       perm_d [MAX_ELEMENTS];
  logic [SIZE_W-1:0]       size_q;
  logic [CW-1:0]           n_eff;
  logic [IW-1:0]           last_idx;
  logic [IW-1:0]           scan_idx_q, scan_idx_d;
  logic [IW-1:0]           fill_idx_q, fill_idx_d;
  logic [ELEM_W-1:0]       prev_q, prev_d;
  logic [ELEM_W-1:0]       cur, succ, low_val;
  logic [MAX_ELEMENTS-1:0] seen_q, seen_d;
  logic [MAX_ELEMENTS-1:0] above_pivot;
  logic [PERM_W-1:0]       packed_now;
  logic [PERM_W-1:0]       out_perm_q;
  logic                    out_fin_q;

  // Position of the lowest set bit, zero for an empty vector.
  function automatic logic [ELEM_W-1:0] lowest_set(input logic [MAX_ELEMENTS-1:0] vec);
    logic [ELEM_W-1:0] pos;
    pos = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = ELEM_W'(i);
      end
    end
    return pos;
  endfunction

  always_comb begin
    if (size_q < SIZE_W'(MIN_ELEMENTS)) begin
      n_eff = CW'(MIN_ELEMENTS);
    end else if (size_q > SIZE_W'(MAX_ELEMENTS)) begin
      n_eff = CW'(MAX_ELEMENTS);
    end else begin
      n_eff = CW'(size_q);
    end
  end

  assign last_idx = IW'(n_eff - CW'(1));

  // The scan walks right to left; seen_q collects the values of the
  // descending suffix, so the new suffix is simply its members in order.
  assign cur = perm_q[scan_idx_q];

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      above_pivot[i] = ELEM_W'(i) > cur;
    end
  end

  assign succ    = lowest_set(seen_q & above_pivot);
  assign low_val = lowest_set(seen_q);

  assign sts_o.ascent    = cur < prev_q;
  assign sts_o.scan_last = scan_idx_q == '0;
  assign sts_o.fill_last = fill_idx_q == last_idx;

  always_comb begin
    perm_d     = perm_q;
    seen_d     = seen_q;
    prev_d     = prev_q;
    scan_idx_d = scan_idx_q;
    fill_idx_d = fill_idx_q;
    if (cmd_i.load_identity) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        perm_d[i] = ELEM_W'(i);
      end
    end
    if (cmd_i.scan_start) begin
      scan_idx_d = last_idx;
      prev_d     = '0;
      seen_d     = '0;
    end
    if (cmd_i.scan_en) begin
      if (sts_o.ascent) begin
        perm_d[scan_idx_q]       = succ;
        seen_d[succ[IW-1:0]]     = 1'b0;
        seen_d[cur[IW-1:0]]      = 1'b1;
        fill_idx_d               = scan_idx_q + IW'(1);
      end else begin
        prev_d                   = cur;
        seen_d[cur[IW-1:0]]      = 1'b1;
        scan_idx_d               = scan_idx_q - IW'(1);
      end
    end
    if (cmd_i.fill_en) begin
      perm_d[fill_idx_q]       = low_val;
      seen_d[low_val[IW-1:0]]  = 1'b0;
      fill_idx_d               = fill_idx_q + IW'(1);
    end
  end

  always_comb begin
    packed_now = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      packed_now[i*ELEM_W +: ELEM_W] = (CW'(i) < n_eff) ? perm_q[i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    perm_q     <= perm_d;
    seen_q     <= seen_d;
    prev_q     <= prev_d;
    scan_idx_q <= scan_idx_d;
    fill_idx_q <= fill_idx_d;
    if (cmd_i.out_load) begin
      out_perm_q <= cmd_i.out_finished ? '0 : packed_now;
      out_fin_q  <= cmd_i.out_finished;
    end
  end

  assign perm_packed_o = out_perm_q;
  assign finished_o    = out_fin_q;

  `LPG_ASSERT_IMPL(a_ascent_has_suffix, cmd_i.scan_en && sts_o.ascent, seen_q != '0,
                   "ascent found with an empty suffix set")
  `LPG_ASSERT_IMPL(a_successor_larger, cmd_i.scan_en && sts_o.ascent, succ > cur,
                   "successor is not larger than the pivot")
  `LPG_ASSERT_NEXT(a_identity_loaded, cmd_i.load_identity,
                   perm_q[0] == '0 && perm_q[1] == ELEM_W'(1),
                   "identity load did not reach the permutation")

endmodule

FILE: src/lpg_ctrl.sv
// ----------------------------------------------------------------------------
// Permutation controller
// Sequences request acceptance, the ascent scan, the suffix refill and the
// hand-off of each result word to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpg_ctrl
  import lpg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_restart_i,
  output logic     req_ready_o,
  input  logic     rsp_ready_i,
  output logic     rsp_valid_o,
  input  logic     cfg_we_i,
  input  lpg_sts_t sts_i,
  output lpg_cmd_t cmd_o
);

  lpg_state_e state_q, state_d;
  logic       running_q, running_d;
  logic       fin_q, fin_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    fin_d       = fin_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          fin_d = 1'b0;
          if (req_restart_i || !running_q) begin
            cmd_o.load_identity = 1'b1;
            running_d           = 1'b1;
            state_d             = ST_DONE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.ascent) begin
          state_d = ST_FILL;
        end else if (sts_i.scan_last) begin
          running_d = 1'b0;
          fin_d     = 1'b1;
          state_d   = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd_o.fill_en = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.out_finished = fin_q;
    // A size write abandons the sequence in progress.
    if (cfg_we_i) begin
      running_d = 1'b0;
    end
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign rsp_valid_o = out_valid_q;

  `LPG_ASSERT_IMPL(a_load_when_free, cmd_o.out_load, !out_valid_q || rsp_ready_i,
                   "result loaded over a word not yet taken")
  `LPG_ASSERT_NEXT(a_exhaust_disarms,
                   state_q == ST_SCAN && !sts_i.ascent && sts_i.scan_last,
                   !running_q && fin_q,
                   "exhausted sequence did not disarm")
  `LPG_ASSERT_IMPL(a_valid_from_done, $rose(out_valid_q), $past(state_q == ST_DONE),
                   "result word appeared outside the done step")

endmodule

FILE: src/lexicographic_permutation_generator.sv
// Sequence: a request loads the identity, or scans for the rightmost ascent and
// refills the suffix, or scans the whole permutation when the sequence is
// exhausted; the result word then waits in the done step until the output
// register is free. A new request is taken only after that hand-off; the scan
// and refill read or write one permutation entry per cycle.
// Reset (rst_ni low, asynchronous) idles the block, drops any pending result,
// sets the size to 16 and clears the running flag; entries are left as is.
// ----------------------------------------------------------------------------
// Lexicographic permutation generator
// Yields the next permutation of 0..n-1 per request, with restart and a
// finished indication once the sequence is exhausted.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator
  import lpg_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpg_req_if.sink    req_i,
  lpg_rsp_if.source  rsp_o,
  lpg_cfg_if.sink    cfg_i
);

  // The controller and the datapath talk only through these two bundles.
  lpg_cmd_t cmd;
  lpg_sts_t sts;
  logic     cfg_we;

  // The size register can always be written. The user is to write it only while
  // idle, which the block does not enforce; a write needs no stall and ends the
  // running sequence so the next request starts from the identity at the new size.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // The controller accepts a request word only when no other request is in
  // flight. The first request after reset, a restart, or the request after an
  // exhausted sequence loads the identity. Otherwise the scan walks from the
  // right end, one entry per cycle, until it meets an ascent; that step writes
  // the successor into the pivot position, and the refill then writes the rest
  // of the suffix in ascending order, one entry per cycle.
  lpg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_restart_i (req_i.restart),
    .req_ready_o   (req_i.ready),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .cfg_we_i      (cfg_we),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // The datapath owns the permutation entries, the suffix value set and the
  // output register. The output register frees the request side: a new
  // request is taken while a finished word still waits downstream.
  lpg_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_size_i    (cfg_i.size_in_use),
    .perm_packed_o (rsp_o.perm_packed),
    .finished_o    (rsp_o.finished)
  );

endmodule
